/* hdl/saturation_recovery_curve_eval_core_defines.svh */
// Assertion macros for the saturation-recovery curve evaluator.
// Uses clk and rst_n of the including module.
`ifndef SATURATION_RECOVERY_CURVE_EVAL_CORE_DEFINES_SVH
`define SATURATION_RECOVERY_CURVE_EVAL_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SRCE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srce assertion failed");
`define SRCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srce assertion failed");
`else
`define SRCE_ASSERT_IMPL(lbl, ante, cons)
`define SRCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/srce_pkg.sv */
// Package for the saturation-recovery curve evaluator: payload types,
// register indexes, elaboration-time exp(-n) table, reciprocal constants and saturation helpers.
`timescale 1ns / 1ps
`default_nettype none
package srce_pkg;

    localparam int unsigned NTERMS = 24;
    localparam int unsigned NPOW   = 32;
    localparam logic [62:0] ONE62  = 63'h4000_0000_0000_0000;

    localparam logic [7:0] CFG_PLATEAU = 8'd0;
    localparam logic [7:0] CFG_RATE    = 8'd1;

    typedef struct packed {
        logic [31:0] time_point;
        logic        in_last;
    } srce_in_t;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic [32:0]        grad_intensity;
        logic signed [63:0] grad_rate;
        logic [31:0]        hess_rate_intensity;
        logic signed [63:0] hess_rate_rate;
        logic               out_last;
    } srce_out_t;

    typedef struct packed {
        logic [31:0] t;
        logic [4:0]  n;
        logic        big;
        logic        last;
    } side_t;

    typedef struct packed {
        logic        valid;
        logic [61:0] f;
        logic [62:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        side_t       side;
    } lane_t;

    function automatic logic [63:0] mul_round62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b} + (128'd1 << 61);
        return p[125:62];
    endfunction

    function automatic logic [63:0] exp_neg_fn(logic [63:0] f);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'(ONE62);
        pos  = 64'(ONE62);
        neg  = 64'd0;
        for (int k = 1; k <= int'(NTERMS); k++) begin
            term = mul_round62(term, f) / 64'(k);
            if ((k % 2) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    function automatic logic [NPOW-1:0][62:0] pow_table_fn();
        logic [NPOW-1:0][62:0] tab;
        logic [63:0] e1;
        logic [63:0] acc;
        e1  = exp_neg_fn(64'(ONE62));
        acc = 64'(ONE62);
        tab[0] = ONE62;
        for (int i = 1; i < int'(NPOW); i++) begin
            acc = mul_round62(acc, e1);
            tab[i] = acc[62:0];
        end
        return tab;
    endfunction

    localparam logic [NPOW-1:0][62:0] POW_TAB = pow_table_fn();

    // ceil(2^(63+clog2(k))/k): floor(x/k) = (x*m) >> (63+clog2(k)) for x < 2^63
    function automatic logic [63:0] recip_fn(int unsigned k);
        logic [127:0] num;
        num = (128'd1 << (63 + $clog2(k))) + 128'(k - 1);
        return 64'(num / 128'(k));
    endfunction

    function automatic logic [31:0] sat32(logic [32:0] mag, logic neg);
        logic [32:0] m;
        logic [32:0] r;
        if (neg) begin
            m = (mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : mag;
            r = 33'd0 - m;
        end
        else begin
            r = (mag > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : mag;
        end
        return r[31:0];
    endfunction

    function automatic logic [63:0] sat64(logic [63:0] mag, logic ovf, logic neg);
        logic [63:0] m;
        if (neg) begin
            m = (ovf || mag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : mag;
            return 64'd0 - m;
        end
        return (ovf || mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
    endfunction

endpackage
`default_nettype wire

/* hdl/srce_term_cell.sv */
// One Taylor-series cell of exp(-f): term = round(term*f)/K, summed by sign.
// Four register stages. Depends on srce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srce_term_cell #(
    parameter int unsigned K = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  srce_pkg::lane_t lane_in,
    output srce_pkg::lane_t lane_out
);
    import srce_pkg::*;

    localparam logic        ODD   = ((K % 2) == 1);
    localparam int unsigned SH    = 63 + $clog2(K);
    localparam logic [63:0] RECIP = recip_fn(K);

    lane_t        s1_reg;
    lane_t        s2_reg;
    lane_t        s3_reg;
    lane_t        lane_out_reg;
    lane_t        lane_next;
    logic [63:0]  pa_hh_reg;
    logic [63:0]  pa_hl_reg;
    logic [63:0]  pa_lh_reg;
    logic [63:0]  pa_ll_reg;
    logic [62:0]  r_reg;
    logic [63:0]  pb_hh_reg;
    logic [63:0]  pb_hl_reg;
    logic [63:0]  pb_lh_reg;
    logic [63:0]  pb_ll_reg;
    logic [127:0] prod;
    logic [127:0] qsum;
    logic [127:0] qsh;
    logic [62:0]  r;
    logic [62:0]  q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_reg       <= '0;
            s3_reg       <= '0;
            lane_out_reg <= '0;
        end
        else if (en)
        begin
            s1_reg       <= lane_in;
            s2_reg       <= s1_reg;
            s3_reg       <= s2_reg;
            lane_out_reg <= lane_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_hh_reg <= {33'd0, lane_in.term[62:32]} * {34'd0, lane_in.f[61:32]};
            pa_hl_reg <= {33'd0, lane_in.term[62:32]} * {32'd0, lane_in.f[31:0]};
            pa_lh_reg <= {32'd0, lane_in.term[31:0]} * {34'd0, lane_in.f[61:32]};
            pa_ll_reg <= {32'd0, lane_in.term[31:0]} * {32'd0, lane_in.f[31:0]};

            r_reg     <= r;

            pb_hh_reg <= {33'd0, r_reg[62:32]} * {32'd0, RECIP[63:32]};
            pb_hl_reg <= {33'd0, r_reg[62:32]} * {32'd0, RECIP[31:0]};
            pb_lh_reg <= {32'd0, r_reg[31:0]} * {32'd0, RECIP[63:32]};
            pb_ll_reg <= {32'd0, r_reg[31:0]} * {32'd0, RECIP[31:0]};
        end
    end

    always_comb
    begin
        prod = {pa_hh_reg, 64'd0} + {32'd0, pa_hl_reg, 32'd0} + {32'd0, pa_lh_reg, 32'd0}
             + {64'd0, pa_ll_reg} + (128'd1 << 61);
        r    = prod[124:62];
        qsum = {pb_hh_reg, 64'd0} + {32'd0, pb_hl_reg, 32'd0} + {32'd0, pb_lh_reg, 32'd0}
             + {64'd0, pb_ll_reg};
        qsh  = qsum >> SH;
        q    = qsh[62:0];
        lane_next      = s3_reg;
        lane_next.term = q;
        if (ODD)
            lane_next.neg = s3_reg.neg + {1'b0, q};
        else
            lane_next.pos = s3_reg.pos + {1'b0, q};
    end

    assign lane_out = lane_out_reg;

endmodule
`default_nettype wire

/* hdl/srce_out_stage.sv */
// Tail of the evaluator: exp(-n)*exp(-f), then value, gradient and Hessian
// products, rounding and saturation. Eight register stages. Depends on srce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srce_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  srce_pkg::lane_t    lane_in,
    input  logic [31:0]        plateau,
    output logic               res_valid,
    output srce_pkg::srce_out_t res
);
    import srce_pkg::*;

    logic [7:0]   vld_reg;
    side_t        a_side_reg, b_side_reg, c_side_reg, d_side_reg;
    logic [63:0]  ef_reg;
    logic [62:0]  pw;
    logic [63:0]  pc_hh_reg, pc_hl_reg, pc_lh_reg, pc_ll_reg;
    logic [127:0] acc_sum;
    logic [63:0]  acc_reg;

    logic [64:0]  e_rnd;
    logic [32:0]  e_val;
    logic [32:0]  imag_full;
    logic [31:0]  imag;
    logic         ineg;
    logic [32:0]  e_reg, g_reg;
    logic [31:0]  imag_reg;
    logic         ineg_reg;

    logic [63:0]  it_reg, te_reg, cv_p_reg;
    logic [32:0]  e2_reg, g2_reg;
    logic         ineg2_reg, last2_reg;

    logic [64:0]  pg_h_reg, pg_l_reg;
    logic [63:0]  ph_hh_reg, ph_hl_reg, ph_lh_reg, ph_ll_reg;
    logic [31:0]  hri_reg;
    logic [31:0]  cv_reg;
    logic [32:0]  g3_reg;
    logic         ineg3_reg, last3_reg;
    logic [64:0]  te_sum;
    logic [64:0]  cv_s;

    logic [96:0]  gr_s;
    logic [128:0] hrr_s;
    logic [63:0]  gr_mag_reg, hrr_mag_reg;
    logic         gr_ovf_reg, hrr_ovf_reg;
    logic [31:0]  cv2_reg, hri2_reg;
    logic [32:0]  g4_reg;
    logic         ineg4_reg, last4_reg;

    srce_out_t    res_next;
    srce_out_t    res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[6:0], lane_in.valid};
    end

    always_comb
    begin
        pw        = POW_TAB[a_side_reg.n];
        acc_sum   = {pc_hh_reg, 64'd0} + {32'd0, pc_hl_reg, 32'd0} + {32'd0, pc_lh_reg, 32'd0}
                  + {64'd0, pc_ll_reg} + (128'd1 << 61);
        e_rnd     = {1'b0, acc_reg} + (65'd1 << 29);
        if (c_side_reg.big)
            e_val = 33'd0;
        else if (e_rnd[64:30] > 35'h1_0000_0000)
            e_val = 33'h1_0000_0000;
        else
            e_val = e_rnd[62:30];
        ineg      = plateau[31];
        imag_full = 33'h1_0000_0000 - {1'b0, plateau};
        imag      = ineg ? imag_full[31:0] : plateau;
        te_sum    = {1'b0, te_reg} + (65'd1 << 31);
        cv_s      = {1'b0, cv_p_reg} + (65'd1 << 31);
        gr_s      = {pg_h_reg, 32'd0} + {32'd0, pg_l_reg} + (97'd1 << 31);
        hrr_s     = {1'b0, ph_hh_reg, 64'd0} + {33'd0, ph_hl_reg, 32'd0}
                  + {33'd0, ph_lh_reg, 32'd0} + {65'd0, ph_ll_reg} + (129'd1 << 47);
        res_next.curve_value         = cv2_reg;
        res_next.grad_intensity      = g4_reg;
        res_next.grad_rate           = sat64(gr_mag_reg, gr_ovf_reg, ineg4_reg);
        res_next.hess_rate_intensity = hri2_reg;
        res_next.hess_rate_rate      = sat64(hrr_mag_reg, hrr_ovf_reg, !ineg4_reg);
        res_next.out_last            = last4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= lane_in.side;
            ef_reg     <= (lane_in.pos > lane_in.neg) ? lane_in.pos - lane_in.neg : 64'd0;

            b_side_reg <= a_side_reg;
            pc_hh_reg  <= {33'd0, pw[62:32]} * {32'd0, ef_reg[63:32]};
            pc_hl_reg  <= {33'd0, pw[62:32]} * {32'd0, ef_reg[31:0]};
            pc_lh_reg  <= {32'd0, pw[31:0]} * {32'd0, ef_reg[63:32]};
            pc_ll_reg  <= {32'd0, pw[31:0]} * {32'd0, ef_reg[31:0]};

            c_side_reg <= b_side_reg;
            acc_reg    <= acc_sum[125:62];

            d_side_reg <= c_side_reg;
            e_reg      <= e_val;
            g_reg      <= 33'h1_0000_0000 - e_val;
            imag_reg   <= imag;
            ineg_reg   <= ineg;

            it_reg     <= {32'd0, imag_reg} * {32'd0, d_side_reg.t};
            te_reg     <= {31'd0, e_reg} * {32'd0, d_side_reg.t};
            cv_p_reg   <= {32'd0, imag_reg} * {31'd0, g_reg};
            e2_reg     <= e_reg;
            g2_reg     <= g_reg;
            ineg2_reg  <= ineg_reg;
            last2_reg  <= d_side_reg.last;

            pg_h_reg   <= {33'd0, it_reg[63:32]} * {32'd0, e2_reg};
            pg_l_reg   <= {33'd0, it_reg[31:0]} * {32'd0, e2_reg};
            ph_hh_reg  <= {32'd0, it_reg[63:32]} * {32'd0, te_reg[63:32]};
            ph_hl_reg  <= {32'd0, it_reg[63:32]} * {32'd0, te_reg[31:0]};
            ph_lh_reg  <= {32'd0, it_reg[31:0]} * {32'd0, te_reg[63:32]};
            ph_ll_reg  <= {32'd0, it_reg[31:0]} * {32'd0, te_reg[31:0]};
            hri_reg    <= te_sum[63:32];
            cv_reg     <= sat32(cv_s[64:32], ineg2_reg);
            g3_reg     <= g2_reg;
            ineg3_reg  <= ineg2_reg;
            last3_reg  <= last2_reg;

            gr_mag_reg  <= gr_s[95:32];
            gr_ovf_reg  <= gr_s[96];
            hrr_mag_reg <= hrr_s[111:48];
            hrr_ovf_reg <= |hrr_s[128:112];
            cv2_reg     <= cv_reg;
            hri2_reg    <= hri_reg;
            g4_reg      <= g3_reg;
            ineg4_reg   <= ineg3_reg;
            last4_reg   <= last3_reg;

            res_reg    <= res_next;
        end
    end

    assign res_valid = vld_reg[7];
    assign res       = res_reg;

endmodule
`default_nettype wire

/* hdl/saturation_recovery_curve_eval_core.sv */
// Top level of the saturation-recovery curve evaluator.
// Depends on srce_pkg, srce_term_cell, srce_out_stage and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "saturation_recovery_curve_eval_core_defines.svh"
// Takes one time point per cycle while in_ready is high and returns one
// result per time point, in order. In order the registers hold R*t, its split,
// a row of 24 Taylor-series cells for exp(-f), the output stage and the
// output register. A skid register behind the output register lets the
// pipeline keep taking transfers while a result waits; in_ready drops only
// when that skid register is full. The user must write registers through the
// cfg channel only while no item is in flight; the block does not enforce it.
module saturation_recovery_curve_eval_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  srce_pkg::srce_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output srce_pkg::srce_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import srce_pkg::*;

    logic [31:0] plateau_reg;
    logic [31:0] rate_reg;
    logic        en;

    logic        s0_valid_reg;
    logic [63:0] x_reg;
    logic [31:0] s0_t_reg;
    logic        s0_last_reg;
    lane_t       lane0_reg;
    lane_t       lane0_next;
    lane_t       lanes [0:NTERMS];

    logic        res_valid;
    srce_out_t   res;
    logic        out_valid_reg;
    srce_out_t   out_reg;
    logic        skid_full_reg;
    srce_out_t   skid_reg;

    assign cfg_ready = 1'b1;
    assign en        = !skid_full_reg;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plateau_reg <= '0;
            rate_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PLATEAU: plateau_reg <= cfg_data;
                CFG_RATE:    rate_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            lane0_reg    <= '0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            lane0_reg    <= lane0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= {32'd0, rate_reg} * {32'd0, in_data.time_point};
            s0_t_reg    <= in_data.time_point;
            s0_last_reg <= in_data.in_last;
        end
    end

    always_comb
    begin
        lane0_next.valid     = s0_valid_reg;
        lane0_next.f         = {x_reg[31:0], 30'd0};
        lane0_next.term      = ONE62;
        lane0_next.pos       = 64'(ONE62);
        lane0_next.neg       = 64'd0;
        lane0_next.side.t    = s0_t_reg;
        lane0_next.side.n    = x_reg[36:32];
        lane0_next.side.big  = |x_reg[63:37];
        lane0_next.side.last = s0_last_reg;
    end

    assign lanes[0] = lane0_reg;

    genvar gi;
    generate
        for (gi = 0; gi < int'(NTERMS); gi++)
        begin : g_cell
            srce_term_cell #(
                .K(gi + 1)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .lane_in (lanes[gi]),
                .lane_out(lanes[gi + 1])
            );
        end
    endgenerate

    srce_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .lane_in  (lanes[NTERMS]),
        .plateau  (plateau_reg),
        .res_valid(res_valid),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                if (skid_full_reg)
                begin
                    out_valid_reg <= 1'b1;
                    skid_full_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= en && res_valid;
                end
            end
            else if (en && res_valid)
            begin
                skid_full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
            out_reg <= skid_full_reg ? skid_reg : res;
        else if (en && res_valid)
            skid_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SRCE_ASSERT_IMPL(a_skid_has_out, skid_full_reg, out_valid_reg)
    `SRCE_ASSERT_NEXT(a_skid_kept, skid_full_reg && !out_ready, skid_full_reg)
    `SRCE_ASSERT_NEXT(a_drain_empty, out_valid_reg && out_ready && !skid_full_reg && !res_valid, !out_valid_reg)

endmodule
`default_nettype wire
